// File: sv/bqb_pkg.sv
// bqb_pkg: shared types and constants of the billboard quad builder
// request structs, controller/datapath command and status, micro-op codes
// no dependencies
package bqb_pkg;

    localparam int MAX_PARTICLES_DEF = 16384;
    localparam int FRAC_BITS_DEF     = 16;

    localparam int IDX_W   = 14;
    localparam int CNT_W   = 15;
    localparam int COORD_W = 32;
    localparam int VIDX_W  = 16;
    localparam int CFG_IDX_W = 2;

    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
    localparam cfg_idx_t REG_CAMERA_X       = 2'd0;
    localparam cfg_idx_t REG_CAMERA_Y       = 2'd1;
    localparam cfg_idx_t REG_CAMERA_Z       = 2'd2;
    localparam cfg_idx_t REG_PARTICLE_LIMIT = 2'd3;

    typedef struct packed {
        logic [IDX_W-1:0]          particle_index;
        logic                      alive;
        logic signed [COORD_W-1:0] pos_x;
        logic signed [COORD_W-1:0] pos_y;
        logic signed [COORD_W-1:0] pos_z;
        logic                      last_particle;
    } in_t;

    typedef struct packed {
        logic                      emitted;
        logic [IDX_W-1:0]          live_slot;
        logic [VIDX_W-1:0]         vertex_index;
        logic [1:0]                corner;
        logic signed [COORD_W-1:0] vert_x;
        logic signed [COORD_W-1:0] vert_y;
        logic signed [COORD_W-1:0] vert_z;
        logic [CNT_W-1:0]          live_count;
        logic                      degenerate;
        logic                      last_of_run;
    } res_t;

    typedef enum logic [4:0] {
        OP_SCALE   = 5'd0,
        OP_MUL_X   = 5'd1,
        OP_MUL_Y   = 5'd2,
        OP_MUL_Z   = 5'd3,
        OP_SQRT_V  = 5'd4,
        OP_DIV_RX  = 5'd5,
        OP_DIV_RY  = 5'd6,
        OP_DIV_RZ  = 5'd7,
        OP_SLOPE1  = 5'd8,
        OP_SLOPE2  = 5'd9,
        OP_MUL_K1  = 5'd10,
        OP_SQRT_T1 = 5'd11,
        OP_DIV_T1A = 5'd12,
        OP_DIV_T1B = 5'd13,
        OP_MUL_K2  = 5'd14,
        OP_SQRT_T2 = 5'd15,
        OP_DIV_T2A = 5'd16,
        OP_DIV_T2B = 5'd17,
        OP_EMIT    = 5'd18
    } op_t;

    typedef enum logic {
        ITER_DIV  = 1'b0,
        ITER_SQRT = 1'b1
    } iter_mode_t;

    typedef struct packed {
        logic go;
        logic load;
        op_t  op;
    } cmd_t;

    typedef struct packed {
        logic live;
        logic last_corner;
        logic out_free;
        logic done;
    } sts_t;

endpackage

// File: sv/bqb_iter.sv
// bqb_iter: shared iterative unit, restoring divide (64/32) or integer square root (64)
// one quotient bit or one root bit per cycle
// depends on bqb_pkg
module bqb_iter (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                start,
    input  bqb_pkg::iter_mode_t mode,
    input  logic [63:0]         opa,
    input  logic [31:0]         opb,
    output logic                done,
    output logic [63:0]         result
);
    import bqb_pkg::*;

    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    iter_mode_t  mode_reg, mode_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic [63:0] a_reg, a_next;
    logic [31:0] b_reg, b_next;
    logic [31:0] rem_reg, rem_next;
    logic [63:0] res_reg, res_next;
    logic [63:0] bit_reg, bit_next;
    logic [32:0] r2;
    logic [32:0] r2_sub;
    logic [63:0] trial;

    assign r2     = {rem_reg, a_reg[63]};
    assign r2_sub = r2 - {1'b0, b_reg};
    assign trial  = res_reg + bit_reg;

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        mode_next = mode_reg;
        cnt_next  = cnt_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        rem_next  = rem_reg;
        res_next  = res_reg;
        bit_next  = bit_reg;
        if (start) begin
            busy_next = 1'b1;
            mode_next = mode;
            cnt_next  = (mode == ITER_SQRT) ? 6'd31 : 6'd63;
            a_next    = opa;
            b_next    = opb;
            rem_next  = '0;
            res_next  = '0;
            bit_next  = 64'd1 << 62;
        end else if (busy_reg) begin
            if (mode_reg == ITER_SQRT) begin
                if (a_reg >= trial) begin
                    a_next   = a_reg - trial;
                    res_next = (res_reg >> 1) + bit_reg;
                end else begin
                    res_next = res_reg >> 1;
                end
                bit_next = bit_reg >> 2;
            end else begin
                if (!r2_sub[32]) begin
                    rem_next = r2_sub[31:0];
                    a_next   = {a_reg[62:0], 1'b1};
                end else begin
                    rem_next = r2[31:0];
                    a_next   = {a_reg[62:0], 1'b0};
                end
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        mode_reg <= mode_next;
        cnt_reg  <= cnt_next;
        a_reg    <= a_next;
        b_reg    <= b_next;
        rem_reg  <= rem_next;
        res_reg  <= res_next;
        bit_reg  <= bit_next;
    end

    assign done   = done_reg;
    assign result = (mode_reg == ITER_SQRT) ? res_reg : a_reg;

endmodule

// File: sv/bqb_datapath.sv
// bqb_datapath: particle registers, squaring multiplier, tangent math, vertex output register
// executes one micro-op per command; holds the live counter
// depends on bqb_pkg and bqb_iter
module bqb_datapath #(
    parameter int MAX_PARTICLES = bqb_pkg::MAX_PARTICLES_DEF,
    parameter int FRAC_BITS     = bqb_pkg::FRAC_BITS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  bqb_pkg::cmd_t                     cmd,
    output bqb_pkg::sts_t                     sts,
    input  bqb_pkg::in_t                      s_data,
    input  logic signed [bqb_pkg::COORD_W-1:0] cam_x,
    input  logic signed [bqb_pkg::COORD_W-1:0] cam_y,
    input  logic signed [bqb_pkg::COORD_W-1:0] cam_z,
    input  logic [bqb_pkg::CNT_W-1:0]         limit,
    output logic                              m_valid,
    input  logic                              m_ready,
    output bqb_pkg::res_t                     m_data
);
    import bqb_pkg::*;

    localparam int RW = FRAC_BITS + 2;
    localparam int VW = COORD_W + 2;
    localparam logic signed [COORD_W-1:0] SMAX = {1'b0, {(COORD_W-1){1'b1}}};
    localparam logic signed [COORD_W-1:0] SMIN = {1'b1, {(COORD_W-1){1'b0}}};

    logic [IDX_W-1:0]          idx_reg;
    logic                      last_reg, live_reg;
    logic signed [COORD_W-1:0] p_reg [3];
    logic signed [COORD_W:0]   d_reg [3];
    logic [COORD_W-2:0]        dm_reg [3];
    logic                      dneg_reg [3];
    logic [63:0]               prod_reg, acc_reg;
    logic [31:0]               len_reg;
    logic signed [RW-1:0]      r_reg [3];
    logic signed [COORD_W-1:0] k1_reg, k2_reg;
    logic signed [RW-1:0]      t1x_reg, t1z_reg, t2x_reg, t2y_reg;
    logic                      deg_reg;
    logic [1:0]                corner_reg;
    logic [CNT_W-1:0]          cnt_reg;
    res_t                      out_reg;
    logic                      out_valid_reg;

    logic                      it_start, it_done;
    iter_mode_t                it_mode;
    logic [63:0]               it_a, it_res;
    logic [31:0]               it_b;
    logic [31:0]               mul_op;
    logic [COORD_W:0]          mag [3];
    logic [COORD_W:0]          mx;
    logic [CNT_W-1:0]          lim_eff;
    logic                      live_in;
    logic                      out_free;
    logic                      finish;
    logic [CNT_W-1:0]          cnt_inc;
    res_t                      res_c;
    logic signed [VW-1:0]      vx, vy, vz;

    function automatic logic [RW-1:0] absr(input logic signed [RW-1:0] v);
        absr = v[RW-1] ? RW'(-v) : RW'(v);
    endfunction

    function automatic logic [31:0] abs32(input logic signed [31:0] v);
        abs32 = v[31] ? 32'(-v) : 32'(v);
    endfunction

    function automatic logic signed [RW-1:0] sgn(input logic neg, input logic [63:0] q);
        logic signed [RW-1:0] m;
        m   = $signed(q[RW-1:0]);
        sgn = neg ? -m : m;
    endfunction

    function automatic logic signed [COORD_W-1:0] slope(input logic [63:0] q,
                                                        input logic signed [RW-1:0] num,
                                                        input logic signed [RW-1:0] den);
        logic neg;
        neg = ((num > 0) != den[RW-1]);
        if (den == 0) begin
            slope = (num <= 0) ? SMAX : SMIN;
        end else if (neg) begin
            slope = (q > 64'h8000_0000) ? SMIN : -$signed(q[31:0]);
        end else begin
            slope = (q > 64'h7FFF_FFFF) ? SMAX : $signed(q[31:0]);
        end
    endfunction

    function automatic logic signed [COORD_W-1:0] sat(input logic signed [VW-1:0] v);
        if (v > VW'(SMAX)) begin
            sat = SMAX;
        end else if (v < VW'(SMIN)) begin
            sat = SMIN;
        end else begin
            sat = v[COORD_W-1:0];
        end
    endfunction

    bqb_iter u_iter (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (it_start),
        .mode    (it_mode),
        .opa     (it_a),
        .opb     (it_b),
        .done    (it_done),
        .result  (it_res)
    );

    // request qualification
    assign lim_eff = (limit < CNT_W'(MAX_PARTICLES)) ? limit : CNT_W'(MAX_PARTICLES);
    assign live_in = s_data.alive && ({1'b0, s_data.particle_index} < lim_eff)
                     && (cnt_reg < CNT_W'(MAX_PARTICLES));

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            mag[i] = d_reg[i][COORD_W] ? (COORD_W+1)'(-d_reg[i]) : (COORD_W+1)'(d_reg[i]);
        end
        mx = mag[0];
        if (mag[1] > mx) mx = mag[1];
        if (mag[2] > mx) mx = mag[2];
    end

    // iterative unit operands
    always_comb begin
        it_start = 1'b0;
        it_mode  = ITER_DIV;
        it_a     = '0;
        it_b     = len_reg;
        case (cmd.op)
            OP_SQRT_V, OP_SQRT_T1, OP_SQRT_T2: begin
                it_start = cmd.go;
                it_mode  = ITER_SQRT;
                it_a     = acc_reg + prod_reg;
            end
            OP_DIV_RX: begin
                it_start = cmd.go;
                it_a     = 64'(dm_reg[0]) << FRAC_BITS;
            end
            OP_DIV_RY: begin
                it_start = cmd.go;
                it_a     = 64'(dm_reg[1]) << FRAC_BITS;
            end
            OP_DIV_RZ: begin
                it_start = cmd.go;
                it_a     = 64'(dm_reg[2]) << FRAC_BITS;
            end
            OP_SLOPE1: begin
                it_start = cmd.go;
                it_a     = 64'(absr(r_reg[0])) << FRAC_BITS;
                it_b     = 32'(absr(r_reg[2]));
            end
            OP_SLOPE2: begin
                it_start = cmd.go;
                it_a     = 64'(absr(r_reg[1])) << FRAC_BITS;
                it_b     = 32'(absr(r_reg[0]));
            end
            OP_DIV_T1A, OP_DIV_T2A: begin
                it_start = cmd.go;
                it_a     = 64'd1 << (2 * FRAC_BITS);
            end
            OP_DIV_T1B: begin
                it_start = cmd.go;
                it_a     = 64'(abs32(k1_reg)) << FRAC_BITS;
            end
            OP_DIV_T2B: begin
                it_start = cmd.go;
                it_a     = 64'(abs32(k2_reg)) << FRAC_BITS;
            end
            default: ;
        endcase
    end

    always_comb begin
        case (cmd.op)
            OP_MUL_Y:  mul_op = 32'(dm_reg[1]);
            OP_MUL_Z:  mul_op = 32'(dm_reg[2]);
            OP_MUL_K1: mul_op = abs32(k1_reg);
            OP_MUL_K2: mul_op = abs32(k2_reg);
            default:   mul_op = 32'(dm_reg[0]);
        endcase
    end

    // vertex for the current corner
    always_comb begin
        vx = VW'(p_reg[0])
           + (corner_reg[1] ? VW'(t1x_reg) : -VW'(t1x_reg))
           + (corner_reg[0] ? VW'(t2x_reg) : -VW'(t2x_reg));
        vy = VW'(p_reg[1]) + (corner_reg[0] ? VW'(t2y_reg) : -VW'(t2y_reg));
        vz = VW'(p_reg[2]) + (corner_reg[1] ? VW'(t1z_reg) : -VW'(t1z_reg));
        cnt_inc = cnt_reg + CNT_W'(1);
        res_c = '0;
        if (live_reg) begin
            res_c.emitted      = 1'b1;
            res_c.live_slot    = cnt_reg[IDX_W-1:0];
            res_c.vertex_index = {idx_reg, corner_reg};
            res_c.corner       = corner_reg;
            res_c.vert_x       = sat(vx);
            res_c.vert_y       = sat(vy);
            res_c.vert_z       = sat(vz);
            res_c.live_count   = cnt_inc;
            res_c.degenerate   = deg_reg;
            res_c.last_of_run  = (corner_reg == 2'd3);
        end else begin
            res_c.live_count   = cnt_reg;
            res_c.last_of_run  = 1'b1;
        end
    end

    assign out_free = !out_valid_reg || m_ready;
    assign finish   = !live_reg || (corner_reg == 2'd3);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cmd.go && cmd.op == OP_EMIT) begin
                out_valid_reg <= 1'b1;
                if (finish) begin
                    if (last_reg) begin
                        cnt_reg <= '0;
                    end else if (live_reg) begin
                        cnt_reg <= cnt_inc;
                    end
                end
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end

        if (cmd.load) begin
            idx_reg    <= s_data.particle_index;
            last_reg   <= s_data.last_particle;
            live_reg   <= live_in;
            p_reg[0]   <= s_data.pos_x;
            p_reg[1]   <= s_data.pos_y;
            p_reg[2]   <= s_data.pos_z;
            d_reg[0]   <= (COORD_W+1)'(cam_x) - (COORD_W+1)'(s_data.pos_x);
            d_reg[1]   <= (COORD_W+1)'(cam_y) - (COORD_W+1)'(s_data.pos_y);
            d_reg[2]   <= (COORD_W+1)'(cam_z) - (COORD_W+1)'(s_data.pos_z);
            deg_reg    <= 1'b0;
            corner_reg <= 2'd0;
        end

        if (cmd.go) begin
            case (cmd.op)
                OP_SCALE: begin
                    for (int i = 0; i < 3; i++) begin
                        dneg_reg[i] <= d_reg[i][COORD_W];
                        if (mx[COORD_W]) begin
                            dm_reg[i] <= mag[i][COORD_W:2];
                        end else if (mx[COORD_W-1]) begin
                            dm_reg[i] <= mag[i][COORD_W-1:1];
                        end else begin
                            dm_reg[i] <= mag[i][COORD_W-2:0];
                        end
                    end
                end
                OP_MUL_X: begin
                    prod_reg <= mul_op * mul_op;
                    acc_reg  <= '0;
                end
                OP_MUL_Y, OP_MUL_Z: begin
                    prod_reg <= mul_op * mul_op;
                    acc_reg  <= acc_reg + prod_reg;
                end
                OP_MUL_K1, OP_MUL_K2: begin
                    prod_reg <= mul_op * mul_op;
                    acc_reg  <= 64'd1 << (2 * FRAC_BITS);
                end
                OP_EMIT: begin
                    if (out_free) begin
                        out_reg <= res_c;
                        if (!finish) corner_reg <= corner_reg + 2'd1;
                    end
                end
                default: ;
            endcase
        end

        if (it_done) begin
            case (cmd.op)
                OP_SQRT_V: begin
                    len_reg <= it_res[31:0];
                    if (it_res == 64'd0) deg_reg <= 1'b1;
                end
                OP_SQRT_T1, OP_SQRT_T2: len_reg <= it_res[31:0];
                OP_DIV_RX: r_reg[0] <= (len_reg == 0) ? '0 : sgn(dneg_reg[0], it_res);
                OP_DIV_RY: r_reg[1] <= (len_reg == 0) ? '0 : sgn(dneg_reg[1], it_res);
                OP_DIV_RZ: r_reg[2] <= (len_reg == 0) ? '0 : sgn(dneg_reg[2], it_res);
                OP_SLOPE1: begin
                    k1_reg <= slope(it_res, r_reg[0], r_reg[2]);
                    if (r_reg[2] == 0) deg_reg <= 1'b1;
                end
                OP_SLOPE2: begin
                    k2_reg <= slope(it_res, r_reg[1], r_reg[0]);
                    if (r_reg[0] == 0) deg_reg <= 1'b1;
                end
                OP_DIV_T1A: t1x_reg <= sgn(1'b0, it_res);
                OP_DIV_T1B: t1z_reg <= sgn(k1_reg[31], it_res);
                OP_DIV_T2A: t2y_reg <= sgn(1'b0, it_res);
                OP_DIV_T2B: t2x_reg <= sgn(k2_reg[31], it_res);
                default: ;
            endcase
        end
    end

    assign sts.live        = live_reg;
    assign sts.last_corner = finish;
    assign sts.out_free    = out_free;
    assign sts.done        = it_done;
    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

endmodule

// File: sv/bqb_ctrl.sv
// bqb_ctrl: sequencer that steps the datapath through the micro-ops of one particle
// drives command, reads status; owns the input handshake
// depends on bqb_pkg
module bqb_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    output bqb_pkg::cmd_t cmd,
    input  bqb_pkg::sts_t sts
);
    import bqb_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_ISSUE,
        S_WAIT,
        S_EMIT
    } state_t;

    state_t state_reg, state_next;
    op_t    op_reg, op_next;
    logic   is_iter;

    always_comb begin
        case (op_reg)
            OP_SQRT_V, OP_DIV_RX, OP_DIV_RY, OP_DIV_RZ, OP_SLOPE1, OP_SLOPE2,
            OP_SQRT_T1, OP_DIV_T1A, OP_DIV_T1B, OP_SQRT_T2, OP_DIV_T2A,
            OP_DIV_T2B: is_iter = 1'b1;
            default:    is_iter = 1'b0;
        endcase
    end

    always_comb begin
        state_next = state_reg;
        op_next    = op_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    state_next = S_ISSUE;
                    op_next    = OP_SCALE;
                end
            end
            S_ISSUE: begin
                if (is_iter) begin
                    state_next = S_WAIT;
                end else if (op_reg == OP_SCALE && !sts.live) begin
                    state_next = S_EMIT;
                    op_next    = OP_EMIT;
                end else begin
                    op_next = op_t'(op_reg + 5'd1);
                end
            end
            S_WAIT: begin
                if (sts.done) begin
                    op_next    = op_t'(op_reg + 5'd1);
                    state_next = (op_reg == OP_DIV_T2B) ? S_EMIT : S_ISSUE;
                end
            end
            S_EMIT: begin
                if (sts.out_free && sts.last_corner) state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            op_reg    <= OP_SCALE;
        end else begin
            state_reg <= state_next;
            op_reg    <= op_next;
        end
    end

    assign s_ready  = (state_reg == S_IDLE);
    assign cmd.load = (state_reg == S_IDLE) && s_valid;
    assign cmd.go   = (state_reg == S_ISSUE) || ((state_reg == S_EMIT) && sts.out_free);
    assign cmd.op   = op_reg;

endmodule

// File: sv/billboard_quad_builder_unit.sv
// billboard_quad_builder_unit: camera-facing quad vertices for a particle stream
// a count-only request goes straight to its result; a live particle first passes through
// the shared bit-serial divide/root unit (nine 64-step divides, three 32-step roots)
// throughput: one request at a time; the next is taken once the last result is registered
// reset: camera (0,0,0), particle_limit 16384, live counter 0, no clearing pass
// depends on bqb_pkg, bqb_ctrl, bqb_datapath
module billboard_quad_builder_unit #(
    parameter int MAX_PARTICLES = bqb_pkg::MAX_PARTICLES_DEF,
    parameter int FRAC_BITS     = bqb_pkg::FRAC_BITS_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  bqb_pkg::in_t                s_data,
    output logic                        m_valid,
    input  logic                        m_ready,
    output bqb_pkg::res_t               m_data,
    input  logic                        cfg_wr_en,
    input  bqb_pkg::cfg_idx_t           cfg_index,
    input  logic [bqb_pkg::COORD_W-1:0] cfg_wdata
);
    import bqb_pkg::*;

    logic signed [COORD_W-1:0] cam_x_reg, cam_y_reg, cam_z_reg;
    logic [CNT_W-1:0]          limit_reg;
    cmd_t                      cmd;
    sts_t                      sts;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cam_x_reg <= '0;
            cam_y_reg <= '0;
            cam_z_reg <= '0;
            limit_reg <= CNT_W'(16384);
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_CAMERA_X:       cam_x_reg <= $signed(cfg_wdata);
                REG_CAMERA_Y:       cam_y_reg <= $signed(cfg_wdata);
                REG_CAMERA_Z:       cam_z_reg <= $signed(cfg_wdata);
                REG_PARTICLE_LIMIT: limit_reg <= cfg_wdata[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    bqb_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .cmd     (cmd),
        .sts     (sts)
    );

    bqb_datapath #(
        .MAX_PARTICLES (MAX_PARTICLES),
        .FRAC_BITS     (FRAC_BITS)
    ) u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .sts     (sts),
        .s_data  (s_data),
        .cam_x   (cam_x_reg),
        .cam_y   (cam_y_reg),
        .cam_z   (cam_z_reg),
        .limit   (limit_reg),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule
